// ----- hw/rtl/tdq_pkg.sv -----
// ----------------------------------------------------------------------------
// tdq_pkg
// shared types and constants of the timer deadline queue
// ----------------------------------------------------------------------------
package tdq_pkg;

	localparam int NUM_TIMERS_DEF = 16;
	localparam int MAX_OUT        = 16;
	localparam int CMD_DEPTH      = 2;
	localparam int RES_DEPTH      = 2;

	localparam int ID_W      = 4;
	localparam int DELAY_W   = 32;
	localparam int ELAPSED_W = 16;
	localparam int TICK_W    = 64;
	localparam int MS_W      = 10;

	localparam logic [1:0] ACT_START = 2'd0;
	localparam logic [1:0] ACT_STOP  = 2'd1;
	localparam logic [1:0] ACT_TICK  = 2'd2;

	localparam logic [1:0] KIND_ACK    = 2'd0;
	localparam logic [1:0] KIND_EXPIRE = 2'd1;
	localparam logic [1:0] KIND_ERR    = 2'd2;
	localparam logic [1:0] KIND_NONE   = 2'd3;

	typedef enum logic [1:0] {
		OP_START,
		OP_STOP,
		OP_TICK,
		OP_BAD
	} tdq_op_t;

	typedef struct packed {
		logic [1:0]           action;
		logic [ID_W-1:0]      timer_id;
		logic [DELAY_W-1:0]   delay_ms;
		logic [ELAPSED_W-1:0] elapsed_ticks;
	} tdq_in_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ID_W-1:0]   expired_id;
		logic [TICK_W-1:0] deadline;
		logic              last;
	} tdq_out_t;

	typedef struct packed {
		tdq_op_t              op;
		logic [ID_W-1:0]      id;
		logic [DELAY_W-1:0]   delay;
		logic [ELAPSED_W-1:0] elapsed;
	} tdq_cmd_t;

endpackage

// ----- hw/rtl/timer_deadline_queue.sv -----
// ----------------------------------------------------------------------------
// timer_deadline_queue
// one-shot timers kept as a min-deadline queue, expiries reported on ticks
//
//   channel   signals                     accepted when
//   input     push, full, item            push && !full
//   result    empty, pop, result          pop && !empty
//   config    cfg_we, cfg_wdata           cfg_we
//
// a start runs the 32-step divider of delay by ms_per_tick before it is acknowledged; a stop reads the deadline back
// a tick scans the deadline memory once per expiry, plus one pass that finds none unless
//   MAX_OUT (sixteen) expiries were found first; a full result queue holds each report
//   until there is room
// reset clears now, all armed bits and the queues; the divisor resets to 1
// a full result queue stalls the back end; the command queue takes two items meanwhile
// ----------------------------------------------------------------------------
module timer_deadline_queue #(
	parameter int NUM_TIMERS = tdq_pkg::NUM_TIMERS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     push,
	input  tdq_pkg::tdq_in_t         item,
	output logic                     full,
	input  logic                     pop,
	output tdq_pkg::tdq_out_t        result,
	output logic                     empty,
	input  logic                     cfg_we,
	input  logic [tdq_pkg::MS_W-1:0] cfg_wdata
);
	import tdq_pkg::*;

	tdq_cmd_t                    cmd;
	logic                        cmd_empty;
	logic                        cmd_pop;
	logic                        res_push;
	logic                        res_full;
	tdq_out_t                    res;
	logic [$bits(tdq_out_t)-1:0] res_raw;

	tdq_front #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item     (item),
		.full     (full),
		.cmd_pop  (cmd_pop),
		.cmd      (cmd),
		.cmd_empty(cmd_empty)
	);

	tdq_back #(
		.NUM_TIMERS(NUM_TIMERS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd),
		.cmd_empty(cmd_empty),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res      (res),
		.res_full (res_full)
	);

	tdq_fifo #(
		.DEPTH(RES_DEPTH),
		.WIDTH($bits(tdq_out_t))
	) u_res_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (res_push),
		.wdata (res),
		.full  (res_full),
		.pop   (pop),
		.rdata (res_raw),
		.empty (empty)
	);

	assign result = tdq_out_t'(res_raw);

	a_none_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_NONE) |-> (result.last && result.deadline == '0))
		else $error("nothing-due item without last or with a deadline");

	a_single_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && (result.kind == KIND_ACK || result.kind == KIND_ERR)) |-> result.last)
		else $error("acknowledge or error item without last");

	a_err_no_deadline: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.kind == KIND_ERR) |-> (result.deadline == '0))
		else $error("error item carries a deadline");

	a_res_held: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_full) |=> (res_push && $stable(res)))
		else $error("result dropped while the result queue was full");

endmodule

// ----- hw/rtl/tdq_fifo.sv -----
// ----------------------------------------------------------------------------
// tdq_fifo
// small synchronous queue of packed items, first word shown while not empty
// ----------------------------------------------------------------------------
module tdq_fifo #(
	parameter int DEPTH = 2,
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wptr_q;
	logic [AW-1:0]    rptr_q;
	logic [AW:0]      cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == (AW+1)'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == AW'(DEPTH - 1)) ? '0 : rptr_q + AW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + (AW+1)'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - (AW+1)'(1);
			end
		end
	end

endmodule

// ----- hw/rtl/tdq_front.sv -----
// ----------------------------------------------------------------------------
// tdq_front
// accepts input items, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module tdq_front #(
	parameter int NUM_TIMERS = tdq_pkg::NUM_TIMERS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  tdq_pkg::tdq_in_t  item,
	output logic              full,
	input  logic              cmd_pop,
	output tdq_pkg::tdq_cmd_t cmd,
	output logic              cmd_empty
);
	import tdq_pkg::*;

	tdq_cmd_t                 cmd_new;
	tdq_op_t                  op;
	logic                     id_bad;
	logic [$bits(tdq_cmd_t)-1:0] cmd_raw;

	assign id_bad = ({28'd0, item.timer_id} >= 32'(NUM_TIMERS));

	always_comb begin
		unique case (item.action)
			ACT_START: op = id_bad ? OP_BAD : OP_START;
			ACT_STOP:  op = id_bad ? OP_BAD : OP_STOP;
			ACT_TICK:  op = OP_TICK;
			default:   op = OP_BAD;
		endcase
	end

	always_comb begin
		cmd_new.op      = op;
		cmd_new.id      = item.timer_id;
		cmd_new.delay   = item.delay_ms;
		cmd_new.elapsed = item.elapsed_ticks;
	end

	tdq_fifo #(
		.DEPTH(CMD_DEPTH),
		.WIDTH($bits(tdq_cmd_t))
	) u_cmd_fifo (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (push),
		.wdata (cmd_new),
		.full  (full),
		.pop   (cmd_pop),
		.rdata (cmd_raw),
		.empty (cmd_empty)
	);

	assign cmd = tdq_cmd_t'(cmd_raw);

endmodule

// ----- hw/rtl/tdq_div.sv -----
// ----------------------------------------------------------------------------
// tdq_div
// restoring divider, one quotient bit per cycle, zero divisor taken as one
// ----------------------------------------------------------------------------
module tdq_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [tdq_pkg::DELAY_W-1:0]  dividend,
	input  logic [tdq_pkg::MS_W-1:0]     divisor,
	output logic                         done,
	output logic [tdq_pkg::DELAY_W-1:0]  quotient
);
	import tdq_pkg::*;

	localparam int StepW = $clog2(DELAY_W);

	logic               busy_q;
	logic               done_q;
	logic [StepW-1:0]   step_q;
	logic [MS_W-1:0]    rem_q;
	logic [MS_W-1:0]    dsr_q;
	logic [DELAY_W-1:0] quo_q;
	logic [MS_W:0]      trial;
	logic [MS_W:0]      diff;
	logic               fits;

	assign trial    = {rem_q, quo_q[DELAY_W-1]};
	assign fits     = (trial >= {1'b0, dsr_q});
	assign diff     = trial - {1'b0, dsr_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + StepW'(1);
				if (step_q == StepW'(DELAY_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= (divisor == '0) ? MS_W'(1) : divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[MS_W-1:0] : trial[MS_W-1:0];
			quo_q <= {quo_q[DELAY_W-2:0], fits};
		end
	end

endmodule

// ----- hw/rtl/tdq_back.sv -----
// ----------------------------------------------------------------------------
// tdq_back
// command sequencer: timer state, deadline memory, expiry scan, result build
// ----------------------------------------------------------------------------
module tdq_back #(
	parameter int NUM_TIMERS = tdq_pkg::NUM_TIMERS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cfg_we,
	input  logic [tdq_pkg::MS_W-1:0] cfg_wdata,
	input  tdq_pkg::tdq_cmd_t        cmd,
	input  logic                     cmd_empty,
	output logic                     cmd_pop,
	output logic                     res_push,
	output tdq_pkg::tdq_out_t        res,
	input  logic                     res_full
);
	import tdq_pkg::*;

	localparam int IW   = $clog2(NUM_TIMERS);
	localparam int CntW = $clog2(MAX_OUT + 1);

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_RD,
		S_SCAN,
		S_SLAST,
		S_SDONE,
		S_FLUSH,
		S_PUSH
	} state_t;

	state_t              state_q;
	state_t              ret_q;
	tdq_cmd_t            cmd_q;
	logic [MS_W-1:0]     ms_q;
	logic [TICK_W-1:0]   now_q;
	logic [NUM_TIMERS-1:0] armed_q;
	tdq_out_t            res_q;
	tdq_out_t            pend_q;
	logic                pend_vld_q;
	logic [CntW-1:0]     cnt_q;
	logic [CntW-1:0]     cnt_n;
	logic [IW-1:0]       scan_idx_q;
	logic                rd_vld_s1;
	logic [IW-1:0]       rd_idx_s1;
	logic                best_vld_q;
	logic [IW-1:0]       best_id_q;
	logic [TICK_W-1:0]   best_due_q;
	logic                cand;

	logic [TICK_W-1:0]   due_mem [NUM_TIMERS];
	logic [TICK_W-1:0]   rdata_q;
	logic [IW-1:0]       raddr;
	logic                mem_we;
	logic [TICK_W-1:0]   sum;

	logic [IW-1:0]       head_idx;
	logic [IW-1:0]       cmd_idx;
	logic                div_start;
	logic                div_done;
	logic [DELAY_W-1:0]  quotient;

	assign head_idx  = IW'(cmd.id);
	assign cmd_idx   = IW'(cmd_q.id);
	assign cmd_pop   = (state_q == S_IDLE);
	assign res_push  = (state_q == S_PUSH);
	assign res       = res_q;
	assign div_start = (state_q == S_IDLE) && !cmd_empty && (cmd.op == OP_START) &&
		!armed_q[head_idx];
	assign sum       = now_q + TICK_W'(quotient);
	assign mem_we    = (state_q == S_DIV) && div_done;
	assign raddr     = (state_q == S_SCAN) ? scan_idx_q : head_idx;
	assign cnt_n     = cnt_q + CntW'(1);
	assign cand      = rd_vld_s1 && armed_q[rd_idx_s1] && (rdata_q <= now_q) &&
		(!best_vld_q || (rdata_q < best_due_q));

	tdq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(cmd.delay),
		.divisor (ms_q),
		.done    (div_done),
		.quotient(quotient)
	);

	always_ff @(posedge clk) begin
		if (mem_we) begin
			due_mem[cmd_idx] <= sum;
		end
		rdata_q <= due_mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ret_q      <= S_IDLE;
			cmd_q      <= '0;
			ms_q       <= MS_W'(1);
			now_q      <= '0;
			armed_q    <= '0;
			res_q      <= '0;
			pend_q     <= '0;
			pend_vld_q <= 1'b0;
			cnt_q      <= '0;
			scan_idx_q <= '0;
			rd_vld_s1  <= 1'b0;
			rd_idx_s1  <= '0;
			best_vld_q <= 1'b0;
			best_id_q  <= '0;
			best_due_q <= '0;
		end else begin
			if (cfg_we) begin
				ms_q <= cfg_wdata;
			end

			// scan pipeline: read issued in S_SCAN, compared in the next cycle
			rd_vld_s1 <= (state_q == S_SCAN);
			rd_idx_s1 <= scan_idx_q;
			if (cand) begin
				best_vld_q <= 1'b1;
				best_id_q  <= rd_idx_s1;
				best_due_q <= rdata_q;
			end

			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						cmd_q <= cmd;
						unique case (cmd.op)
							OP_START: begin
								if (armed_q[head_idx]) begin
									res_q   <= '{KIND_ERR, cmd.id, '0, 1'b1};
									ret_q   <= S_IDLE;
									state_q <= S_PUSH;
								end else begin
									state_q <= S_DIV;
								end
							end
							OP_STOP: begin
								if (!armed_q[head_idx]) begin
									res_q   <= '{KIND_ERR, cmd.id, '0, 1'b1};
									ret_q   <= S_IDLE;
									state_q <= S_PUSH;
								end else begin
									state_q <= S_RD;
								end
							end
							OP_TICK: begin
								now_q      <= now_q + TICK_W'(cmd.elapsed);
								cnt_q      <= '0;
								pend_vld_q <= 1'b0;
								scan_idx_q <= '0;
								best_vld_q <= 1'b0;
								state_q    <= S_SCAN;
							end
							OP_BAD: begin
								res_q   <= '{KIND_ERR, cmd.id, '0, 1'b1};
								ret_q   <= S_IDLE;
								state_q <= S_PUSH;
							end
						endcase
					end
				end
				S_DIV: begin
					if (div_done) begin
						armed_q[cmd_idx] <= 1'b1;
						res_q   <= '{KIND_ACK, cmd_q.id, sum, 1'b1};
						ret_q   <= S_IDLE;
						state_q <= S_PUSH;
					end
				end
				S_RD: begin
					armed_q[cmd_idx] <= 1'b0;
					res_q   <= '{KIND_ACK, cmd_q.id, rdata_q, 1'b1};
					ret_q   <= S_IDLE;
					state_q <= S_PUSH;
				end
				S_SCAN: begin
					if (scan_idx_q == IW'(NUM_TIMERS - 1)) begin
						state_q <= S_SLAST;
					end else begin
						scan_idx_q <= scan_idx_q + IW'(1);
					end
				end
				S_SLAST: begin
					state_q <= S_SDONE;
				end
				S_SDONE: begin
					scan_idx_q <= '0;
					best_vld_q <= 1'b0;
					if (best_vld_q) begin
						// hold the find until the next round tells whether it is the last
						armed_q[best_id_q] <= 1'b0;
						pend_q     <= '{KIND_EXPIRE, ID_W'(best_id_q), best_due_q, 1'b0};
						pend_vld_q <= 1'b1;
						cnt_q      <= cnt_n;
						if (pend_vld_q) begin
							res_q   <= pend_q;
							ret_q   <= (cnt_n == CntW'(MAX_OUT)) ? S_FLUSH : S_SCAN;
							state_q <= S_PUSH;
						end else begin
							state_q <= (cnt_n == CntW'(MAX_OUT)) ? S_FLUSH : S_SCAN;
						end
					end else begin
						if (pend_vld_q) begin
							res_q <= '{pend_q.kind, pend_q.expired_id, pend_q.deadline, 1'b1};
						end else begin
							res_q <= '{KIND_NONE, '0, '0, 1'b1};
						end
						ret_q   <= S_IDLE;
						state_q <= S_PUSH;
					end
				end
				S_FLUSH: begin
					res_q   <= '{pend_q.kind, pend_q.expired_id, pend_q.deadline, 1'b1};
					ret_q   <= S_IDLE;
					state_q <= S_PUSH;
				end
				S_PUSH: begin
					if (!res_full) begin
						state_q <= ret_q;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
